// ===== hw/rtl/wdtl_pkg.sv =====
// Package for the wildcard domain table lookup: commands, search states, header layout.
// No dependencies.
`timescale 1ns / 1ps
package wdtl_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_HDR  = 2'd0,
    CMD_LOAD_BYTE = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_SRCH_START,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_STRIP_RD,
    ST_STRIP_CHK,
    ST_DONE
  } state_e;

  // Entry header as stored: level, name length, reply flag.
  typedef struct packed {
    logic [2:0] level;
    logic [7:0] length;
    logic       reply;
  } hdr_t;

  localparam int unsigned HdrW = 12;

endpackage

// ===== hw/rtl/wdtl_if.sv =====
// Valid/ready channel interface carrying one request payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface wdtl_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wdtl_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module wdtl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/wildcard_domain_table_lookup.sv =====
// Wildcard domain table lookup: sorted table, binary search with label stripping.
// Loads write the stores directly on acceptance; a query search counts the labels, then at
// each level binary-searches the table, reading each probe's header and comparing bytes,
// over up to log2(entries) + 1 probes a level, stripping a label between levels, then presents the result.
// Throughput: one request at a time while searching (name store port bound).
// Reset clears control state and the table size register; stores are undefined until written.
`timescale 1ns / 1ps
module wildcard_domain_table_lookup
  import wdtl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES        = 1024,
  parameter int unsigned NAME_SLOT          = 256,
  parameter int unsigned MAX_WILDCARD_LEVEL = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  wdtl_if.sink        req_i,
  wdtl_if.source      rsp_o
);
  localparam int unsigned IdxW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned PosW  = $clog2(NAME_SLOT);
  localparam int unsigned NameW = IdxW + PosW;

  // Request payload fields.
  logic [1:0]  f_cmd;
  logic [9:0]  f_idx;
  logic [2:0]  f_lvl;
  logic [7:0]  f_len;
  logic        f_rep;
  logic [7:0]  f_pos;
  logic [7:0]  f_val;
  logic        f_last;
  assign f_cmd  = req_i.data.cmd;
  assign f_idx  = req_i.data.entry_index;
  assign f_lvl  = req_i.data.entry_level;
  assign f_len  = req_i.data.entry_name_length;
  assign f_rep  = req_i.data.entry_has_reply;
  assign f_pos  = req_i.data.byte_pos;
  assign f_val  = req_i.data.byte_value;
  assign f_last = req_i.data.last;

  state_e state_q, state_d;

  logic [CntW-1:0] count_q;
  logic [7:0]  qlen_q, qlen_d;
  logic [7:0]  pos_q, pos_d;       // label count walk / search offset
  logic [7:0]  len_q, len_d;       // suffix length
  logic [7:0]  labs_q, labs_d;     // labels remaining
  logic [2:0]  lvl_q, lvl_d;       // search level
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0] mid_q, mid_d;
  logic [7:0]  j_q, j_d;
  logic [7:0]  m_q, m_d;
  logic        out_valid_q, out_valid_d;
  logic        out_found_q, out_found_d;
  logic [9:0]  out_idx_q, out_idx_d;
  logic [2:0]  out_lvl_q, out_lvl_d;

  logic        accept;
  assign accept = req_i.valid && req_i.ready;

  // Stores.
  logic            hdr_we;
  logic [IdxW-1:0] hdr_raddr;
  logic [HdrW-1:0] hdr_rdata;
  hdr_t            hdr_w, hdr_r;
  assign hdr_we = accept && f_cmd == CMD_LOAD_HDR && 32'(f_idx) < MAX_ENTRIES;
  assign hdr_w  = '{level: f_lvl, length: f_len, reply: f_rep};
  assign hdr_r  = hdr_t'(hdr_rdata);

  wdtl_ram #(.Width(HdrW), .Depth(MAX_ENTRIES)) u_hdr (
    .clk_i, .we_i(hdr_we), .waddr_i(IdxW'(f_idx)), .wdata_i(HdrW'(hdr_w)),
    .raddr_i(hdr_raddr), .rdata_o(hdr_rdata)
  );

  logic             nm_we;
  logic [NameW-1:0] nm_raddr;
  logic [7:0]       nm_rdata;
  assign nm_we = accept && f_cmd == CMD_LOAD_BYTE && 32'(f_idx) < MAX_ENTRIES
                 && 32'(f_pos) < NAME_SLOT;

  wdtl_ram #(.Width(8), .Depth(MAX_ENTRIES * NAME_SLOT)) u_name (
    .clk_i, .we_i(nm_we), .waddr_i({IdxW'(f_idx), PosW'(f_pos)}), .wdata_i(f_val),
    .raddr_i(nm_raddr), .rdata_o(nm_rdata)
  );

  logic       qb_we;
  logic [7:0] qb_raddr, qb_rdata;
  assign qb_we = accept && f_cmd == CMD_QUERY;

  wdtl_ram #(.Width(8), .Depth(256)) u_qbuf (
    .clk_i, .we_i(qb_we), .waddr_i(f_pos), .wdata_i(f_val),
    .raddr_i(qb_raddr), .rdata_o(qb_rdata)
  );

  // Entry byte beyond the stored width compares as zero.
  logic       j_in_range;
  logic [7:0] ebyte;
  assign j_in_range = 32'(j_q) < NAME_SLOT;
  assign ebyte      = j_in_range ? nm_rdata : 8'd0;

  assign req_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data.found       = out_found_q;
  assign rsp_o.data.match_index = out_idx_q;
  assign rsp_o.data.match_level = out_lvl_q;

  // Working values.
  logic [CntW-1:0] span, mid_full;
  logic [8:0]      lab_end, strip;
  assign span     = hi_q - lo_q;
  assign mid_full = lo_q + (span >> 1);
  assign lab_end  = 9'(pos_q) + 9'(qb_rdata) + 9'd1;
  assign strip    = 9'(qb_rdata) + 9'd1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && f_cmd == CMD_QUERY && f_last) state_d = ST_CNT_RD;
      end
      ST_CNT_RD: begin
        state_d = (pos_q < qlen_q) ? ST_CNT_CHK : ST_SRCH_START;
      end
      ST_CNT_CHK: begin
        if (qb_rdata == 8'd0 || lab_end > 9'(qlen_q)) state_d = ST_SRCH_START;
        else state_d = ST_CNT_RD;
      end
      ST_SRCH_START: begin
        if (labs_q == 8'd0) state_d = ST_DONE;
        else state_d = ST_PROBE_RD;
      end
      ST_PROBE_RD:  state_d = (lo_q < hi_q) ? ST_PROBE_CHK : ST_STRIP_RD;
      ST_PROBE_CHK: state_d = ST_CMP_RD;
      ST_CMP_RD:    state_d = ST_CMP_CHK;
      ST_CMP_CHK:   state_d = ST_CMP_RD;
      ST_STRIP_RD:  state_d = ST_STRIP_CHK;
      ST_STRIP_CHK: state_d = ST_PROBE_RD;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
    // Compare outcomes override the default paths above.
    if (state_q == ST_PROBE_CHK && hdr_r.level != lvl_q) state_d = ST_PROBE_RD;
    if (state_q == ST_PROBE_CHK && hdr_r.level == lvl_q && m_d == 8'd0) begin
      state_d = (len_q == hdr_r.length) ? ST_DONE : ST_PROBE_RD;
    end
    if (state_q == ST_CMP_CHK) begin
      if (qb_rdata != ebyte) state_d = ST_PROBE_RD;
      else if (j_q + 8'd1 == m_q) state_d = (len_q == hdr_r.length) ? ST_DONE : ST_PROBE_RD;
    end
    if (state_q == ST_PROBE_RD && !(lo_q < hi_q) && lvl_q == 3'd0 && labs_q == 8'd1) begin
      state_d = ST_DONE;
    end
    if (state_q == ST_STRIP_RD && labs_q <= 8'd1) state_d = ST_DONE;
    if (state_q == ST_DONE && !out_valid_q) state_d = ST_DONE;
    if (state_q == ST_DONE && out_valid_q) state_d = ST_DONE;
    if (state_q == ST_DONE && out_valid_q && rsp_o.ready) state_d = ST_IDLE;
  end

  // Datapath and outputs.
  logic hit_now, less_now, greater_now, decided;
  always_comb begin
    qlen_d = qlen_q; pos_d = pos_q; len_d = len_q; labs_d = labs_q; lvl_d = lvl_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; j_d = j_q; m_d = m_q;
    out_valid_d = out_valid_q; out_found_d = out_found_q;
    out_idx_d = out_idx_q; out_lvl_d = out_lvl_q;
    hdr_raddr = mid_q;
    nm_raddr  = {mid_q, PosW'(j_q)};
    qb_raddr  = pos_q;
    hit_now = 1'b0; less_now = 1'b0; greater_now = 1'b0; decided = 1'b0;
    if (rsp_o.valid && rsp_o.ready) out_valid_d = 1'b0;
    m_d = (len_q < hdr_r.length) ? len_q : hdr_r.length;

    case (state_q)
      ST_IDLE: begin
        if (accept && f_cmd == CMD_QUERY && f_last) begin
          qlen_d = (f_pos == 8'hFF) ? 8'hFF : f_pos + 8'd1;
          pos_d  = 8'd0;
          labs_d = 8'd0;
        end
      end
      ST_CNT_RD: begin
        qb_raddr = pos_q;
        if (!(pos_q < qlen_q)) begin
          pos_d = 8'd0;
          len_d = qlen_q;
          lvl_d = 3'd0;
        end
      end
      ST_CNT_CHK: begin
        if (qb_rdata == 8'd0 || lab_end > 9'(qlen_q)) begin
          pos_d = 8'd0;
          len_d = qlen_q;
          lvl_d = 3'd0;
        end else begin
          labs_d = labs_q + 8'd1;
          pos_d  = lab_end[7:0];
        end
      end
      ST_SRCH_START: begin
        lo_d = '0;
        hi_d = count_q;
        out_found_d = 1'b0; out_idx_d = '0; out_lvl_d = '0;
      end
      ST_PROBE_RD: begin
        mid_d     = IdxW'(mid_full);
        hdr_raddr = IdxW'(mid_full);
        j_d       = 8'd0;
        qb_raddr  = pos_q;
        nm_raddr  = {IdxW'(mid_full), PosW'(0)};
        if (!(lo_q < hi_q) && lvl_q == 3'd0 && labs_q == 8'd1) begin
          out_valid_d = 1'b1;
        end
      end
      ST_PROBE_CHK: begin
        if (hdr_r.level != lvl_q) begin
          greater_now = lvl_q > hdr_r.level;
          less_now    = !greater_now;
          decided     = 1'b1;
        end else if (m_d == 8'd0) begin
          hit_now     = len_q == hdr_r.length;
          less_now    = len_q < hdr_r.length;
          greater_now = len_q > hdr_r.length;
          decided     = 1'b1;
        end
      end
      ST_CMP_RD: begin
        qb_raddr = pos_q + j_q;
        nm_raddr = {mid_q, PosW'(j_q)};
      end
      ST_CMP_CHK: begin
        qb_raddr = pos_q + j_q;
        if (qb_rdata != ebyte) begin
          less_now    = qb_rdata < ebyte;
          greater_now = !less_now;
          decided     = 1'b1;
        end else if (j_q + 8'd1 == m_q) begin
          hit_now     = len_q == hdr_r.length;
          less_now    = len_q < hdr_r.length;
          greater_now = len_q > hdr_r.length;
          decided     = 1'b1;
        end else begin
          j_d = j_q + 8'd1;
        end
      end
      ST_STRIP_RD: begin
        qb_raddr = pos_q;
        if (labs_q <= 8'd1) out_valid_d = 1'b1;
      end
      ST_STRIP_CHK: begin
        len_d  = (9'(len_q) >= strip) ? len_q - strip[7:0] : 8'd0;
        pos_d  = pos_q + strip[7:0];
        labs_d = labs_q - 8'd1;
        lvl_d  = 3'((labs_q - 8'd1) & 8'h07);
        lo_d   = '0;
        // Levels above the wildcard limit skip the search entirely.
        hi_d   = (32'(labs_q - 8'd1) <= MAX_WILDCARD_LEVEL) ? count_q : '0;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase

    if (state_q == ST_SRCH_START && labs_q == 8'd0) out_valid_d = 1'b1;
    if (state_q == ST_CMP_RD) m_d = m_q;
    if (state_q == ST_CMP_CHK) m_d = m_q;

    if (decided) begin
      if (hit_now) begin
        if (lvl_q == 3'd0) begin
          out_valid_d = 1'b1;
          out_found_d = hdr_r.reply;
          out_idx_d   = hdr_r.reply ? 10'(mid_q) : 10'd0;
          out_lvl_d   = 3'd0;
        end else if (hdr_r.reply) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_idx_d   = 10'(mid_q);
          out_lvl_d   = lvl_q;
        end else begin
          lo_d = hi_q; // no reply: move on to the next strip
        end
      end else if (less_now) begin
        hi_d = CntW'(mid_q);
      end else if (greater_now) begin
        lo_d = CntW'(mid_q) + CntW'(1);
      end
    end
  end

  // Hits with no reply at wildcard level resume via the strip path.
  logic resume;
  assign resume = decided && hit_now && lvl_q != 3'd0 && !hdr_r.reply;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      qlen_q      <= '0;
      labs_q      <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (resume) state_q <= ST_PROBE_RD;
      else if (out_valid_d && !out_valid_q) state_q <= ST_DONE;
      else state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= (32'(cfg_wdata_i) > MAX_ENTRIES) ? CntW'(MAX_ENTRIES)
                                                     : CntW'(cfg_wdata_i);
      end
      qlen_q      <= qlen_d;
      labs_q      <= labs_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; len_q <= len_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    j_q <= j_d; m_q <= m_d;
    out_found_q <= out_found_d; out_idx_q <= out_idx_d; out_lvl_q <= out_lvl_d;
  end
endmodule
